>>> design/ycbcr_to_rgb_subsampled_unit_assert.svh
// Assertion macros shared by the colour conversion unit.
`ifndef YCBCR_TO_RGB_SUBSAMPLED_UNIT_ASSERT_SVH
`define YCBCR_TO_RGB_SUBSAMPLED_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define YRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("colour conversion assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define YRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("colour conversion assertion failed");

`endif

>>> design/ycc2rgb_pkg.sv
// Types, constants and helpers for the YCbCr to RGB conversion unit.
`timescale 1ns / 1ps
package ycc2rgb_pkg;

    // Q16 chroma coefficients, as signed operands for the multipliers.
    localparam logic signed [17:0] C_COEF_CR_R = 18'sd89849;
    localparam logic signed [17:0] C_COEF_CR_G = 18'sd45744;
    localparam logic signed [17:0] C_COEF_CB_G = 18'sd22020;
    localparam logic signed [17:0] C_COEF_CB_B = 18'sd113508;
    localparam logic signed [8:0]  C_CHROMA_MID = 9'sd128;

    // Reset values of the replacement registers.
    localparam logic [7:0] C_UNDERFLOW_RESET = 8'd16;
    localparam logic [7:0] C_OVERFLOW_RESET  = 8'd240;

    // Configuration register indexes.
    localparam logic C_CFG_UNDERFLOW = 1'b0;
    localparam logic C_CFG_OVERFLOW  = 1'b1;

    // Product width: 9-bit signed chroma times 18-bit signed coefficient.
    localparam int unsigned C_PROD_W = 27;

    // Pixel positions inside an item: index bit 0 is the column, bit 1 the row.
    localparam int unsigned C_NUM_PIX = 4;

    // Raw input beat.
    typedef struct packed {
        logic [1:0]       mode;
        logic [3:0][7:0]  luma;     // top-left, top-right, bottom-left, bottom-right
        logic [7:0]       cb;
        logic [7:0]       cr;
        logic             right;
        logic             below;
    } t_raw_item;

    // Item after the chroma terms have been worked out.
    typedef struct packed {
        logic [3:0][7:0]    luma;
        logic [3:0]         mask;   // pixels still to be produced
        logic signed [8:0]  term_r; // floor of chroma contribution / 65536
        logic signed [8:0]  term_g;
        logic signed [8:0]  term_b;
    } t_conv_item;

    // Add luma to a chroma term and replace out-of-range results.
    function automatic logic [7:0] chan_clamp(input logic [7:0] luma,
                                              input logic signed [8:0] term,
                                              input logic [7:0] under_val,
                                              input logic [7:0] over_val);
        logic signed [10:0] sum;
        logic [7:0]         res;
        sum = $signed({3'b000, luma}) + 11'(term);
        if (sum < 0) begin
            res = under_val;
        end else if (sum > 11'sd255) begin
            res = over_val;
        end else begin
            res = sum[7:0];
        end
        return res;
    endfunction

endpackage

>>> design/ycbcr_to_rgb_subsampled_unit.sv
// YCbCr to RGB conversion unit with 4:4:4, 4:2:2 and 4:2:0 chroma sharing.
//
// Input channel (i_valid / o_stall): one beat carries a chroma pair, up to
// four luma samples, the sampling mode and the right and below edge flags.
// Output channel (o_valid / i_stall): one beat per produced pixel, in the
// order top-left, top-right, bottom-left, bottom-right, with column and row
// offsets and a last-pixel flag on the final pixel of each input beat.
// Out-of-range channels take the underflow or overflow register value; the
// user must write both through the plain write port only while the unit is
// idle, which the unit does not enforce. The first pixel of a beat passes
// through chroma stages one to three, the serialiser and the output register.
// Throughput is set by the pixel serialiser, which produces one pixel per cycle
// while the receiver does not stall, so 4:4:4 beats flow at one per cycle.
// The three chroma stages in front of the serialiser keep accepting while
// it is busy until they fill up.
// Reset empties all stages and loads underflow 16 and overflow 240.
// When the receiver stalls, the output beat holds and the stages behind it
// fill in turn before o_stall is raised; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "ycbcr_to_rgb_subsampled_unit_assert.svh"
module ycbcr_to_rgb_subsampled_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_luma_top_left,
    input  logic [7:0] i_luma_top_right,
    input  logic [7:0] i_luma_bottom_left,
    input  logic [7:0] i_luma_bottom_right,
    input  logic [7:0] i_chroma_blue,
    input  logic [7:0] i_chroma_red,
    input  logic       i_right_present,
    input  logic       i_below_present,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic       o_col_offset,
    output logic       o_row_offset,
    output logic       o_last_pixel,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import ycc2rgb_pkg::*;

    t_raw_item   raw_item;
    t_conv_item  pipe_item;
    logic        pipe_valid;
    logic        pipe_stall;

    logic [7:0]  r_under_val;
    logic [7:0]  r_over_val;

    logic        r_ser_valid;
    t_conv_item  r_ser;
    logic [3:0]  sel_onehot;
    logic [1:0]  sel_idx;
    logic        ser_last;
    logic        ser_emit;
    logic        ser_ready;
    logic        out_ready;

    logic        r_out_valid;
    logic [7:0]  r_red, r_green, r_blue;
    logic        r_col, r_row, r_last;

    // Pack the input beat for the chroma pipeline.
    always_comb begin
        raw_item.mode  = i_mode;
        raw_item.luma  = {i_luma_bottom_right, i_luma_bottom_left,
                          i_luma_top_right, i_luma_top_left};
        raw_item.cb    = i_chroma_blue;
        raw_item.cr    = i_chroma_red;
        raw_item.right = i_right_present;
        raw_item.below = i_below_present;
    end

    ycc2rgb_chroma_pipe u_chroma_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (raw_item),
        .o_valid (pipe_valid),
        .i_stall (pipe_stall),
        .o_item  (pipe_item)
    );

    // Replacement registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_under_val <= C_UNDERFLOW_RESET;
            r_over_val  <= C_OVERFLOW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                C_CFG_UNDERFLOW: r_under_val <= i_cfg_data;
                C_CFG_OVERFLOW:  r_over_val  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pick the lowest pending pixel of the held item.
    always_comb begin
        sel_onehot = r_ser.mask & (~r_ser.mask + 4'd1);
        case (sel_onehot)
            4'b0010: sel_idx = 2'd1;
            4'b0100: sel_idx = 2'd2;
            4'b1000: sel_idx = 2'd3;
            default: sel_idx = 2'd0;
        endcase
        ser_last = ((r_ser.mask & ~sel_onehot) == 4'b0000);
    end

    // Handshake between serialiser, output register and pipeline.
    assign out_ready  = !r_out_valid || !i_stall;
    assign ser_emit   = r_ser_valid && out_ready;
    assign ser_ready  = !r_ser_valid || (ser_emit && ser_last);
    assign pipe_stall = !ser_ready;

    // Serialiser control: take a new item when empty or once the last pixel leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
        end else if (ser_ready) begin
            r_ser_valid <= pipe_valid;
        end
    end

    // Serialiser payload: load a new item or retire the pixel just sent.
    always_ff @(posedge i_clk) begin
        if (ser_ready && pipe_valid) begin
            r_ser <= pipe_item;
        end else if (ser_emit) begin
            r_ser.mask <= r_ser.mask & ~sel_onehot;
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_ser_valid;
        end
    end

    // Output register payload: luma plus chroma terms, then range replacement.
    always_ff @(posedge i_clk) begin
        if (ser_emit) begin
            r_red   <= chan_clamp(r_ser.luma[sel_idx], r_ser.term_r, r_under_val, r_over_val);
            r_green <= chan_clamp(r_ser.luma[sel_idx], r_ser.term_g, r_under_val, r_over_val);
            r_blue  <= chan_clamp(r_ser.luma[sel_idx], r_ser.term_b, r_under_val, r_over_val);
            r_col   <= sel_idx[0];
            r_row   <= sel_idx[1];
            r_last  <= ser_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;
    assign o_col_offset = r_col;
    assign o_row_offset = r_row;
    assign o_last_pixel = r_last;

    // A held item always has at least one pixel left to send.
    `YRS_ASSERT_NOW(a_ser_mask_nonempty, i_clk, i_rst_n, r_ser_valid, r_ser.mask != 4'b0000)
    // While a non-final pixel is on the output, the rest of its item is held.
    `YRS_ASSERT_NOW(a_rest_held, i_clk, i_rst_n, r_out_valid && !r_last, r_ser_valid)
    // A pending pixel with a free output register is sent in the next cycle.
    `YRS_ASSERT_NEXT(a_ser_drains, i_clk, i_rst_n, r_ser_valid && !r_out_valid, r_out_valid)

endmodule

>>> design/ycc2rgb_chroma_pipe.sv
// Three-stage pipeline that turns a chroma pair into per-channel Q0 terms.
`timescale 1ns / 1ps
module ycc2rgb_chroma_pipe (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  ycc2rgb_pkg::t_raw_item  i_item,
    output logic                    o_valid,
    input  logic                    i_stall,
    output ycc2rgb_pkg::t_conv_item o_item
);
    import ycc2rgb_pkg::*;

    typedef struct packed {
        logic [3:0][7:0]   luma;
        logic [3:0]        mask;
        logic signed [8:0] cb;
        logic signed [8:0] cr;
    } t_offs_item;

    typedef struct packed {
        logic [3:0][7:0]            luma;
        logic [3:0]                 mask;
        logic signed [C_PROD_W-1:0] p_cr_r;
        logic signed [C_PROD_W-1:0] p_cb_g;
        logic signed [C_PROD_W-1:0] p_cr_g;
        logic signed [C_PROD_W-1:0] p_cb_b;
    } t_prod_item;

    logic        r_v1, r_v2, r_v3;
    t_offs_item  r_s1, n_s1;
    t_prod_item  r_s2, n_s2;
    t_conv_item  r_s3, n_s3;
    logic        adv1, adv2, adv3;
    logic        quad, pair;
    logic signed [C_PROD_W+1:0] g_neg;

    // Each stage moves on when it is empty or the stage after it moves.
    assign adv3    = !r_v3 || !i_stall;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;

    // Stage one: chroma offsets and the set of pixels to produce.
    // The high mode bit selects the quad, so the reserved code acts as 4:2:0.
    always_comb begin
        quad       = i_item.mode[1];
        pair       = (i_item.mode != 2'b00);
        n_s1.luma  = i_item.luma;
        n_s1.mask  = {quad & i_item.below & i_item.right,
                      quad & i_item.below,
                      pair & i_item.right,
                      1'b1};
        n_s1.cb    = $signed({1'b0, i_item.cb}) - C_CHROMA_MID;
        n_s1.cr    = $signed({1'b0, i_item.cr}) - C_CHROMA_MID;
    end

    // Stage two: the four coefficient products.
    always_comb begin
        n_s2.luma   = r_s1.luma;
        n_s2.mask   = r_s1.mask;
        n_s2.p_cr_r = C_PROD_W'(r_s1.cr) * C_PROD_W'(C_COEF_CR_R);
        n_s2.p_cb_g = C_PROD_W'(r_s1.cb) * C_PROD_W'(C_COEF_CB_G);
        n_s2.p_cr_g = C_PROD_W'(r_s1.cr) * C_PROD_W'(C_COEF_CR_G);
        n_s2.p_cb_b = C_PROD_W'(r_s1.cb) * C_PROD_W'(C_COEF_CB_B);
    end

    // Stage three: green sum, then floor by 65536. Luma has no fraction bits,
    // so flooring the chroma term alone gives the same result per pixel.
    always_comb begin
        g_neg       = -((C_PROD_W+2)'(r_s2.p_cb_g) + (C_PROD_W+2)'(r_s2.p_cr_g));
        n_s3.luma   = r_s2.luma;
        n_s3.mask   = r_s2.mask;
        n_s3.term_r = r_s2.p_cr_r[24:16];
        n_s3.term_g = g_neg[24:16];
        n_s3.term_b = r_s2.p_cb_b[24:16];
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1 <= n_s1;
        end
        if (adv2) begin
            r_s2 <= n_s2;
        end
        if (adv3) begin
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_s3;

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the subsampled YCbCr to RGB conversion unit.
`timescale 1ns / 1ps
module tb_top;
    import ycc2rgb_pkg::*;

    // Chroma sharing modes as carried on i_mode.
    typedef enum logic [1:0] {
        MODE_444  = 2'd0,
        MODE_422  = 2'd1,
        MODE_420  = 2'd2,
        MODE_RSVD = 2'd3
    } t_sampling;

    // Q16 chroma coefficients and the chroma mid-point.
    localparam int CR_TO_RED   = 89849;
    localparam int CR_TO_GREEN = 45744;
    localparam int CB_TO_GREEN = 22020;
    localparam int CB_TO_BLUE  = 113508;
    localparam int CHROMA_ZERO = 128;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_QUADS  = 80;

    typedef struct {
        t_sampling  mode;
        logic [7:0] y_tl;
        logic [7:0] y_tr;
        logic [7:0] y_bl;
        logic [7:0] y_br;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       right;
        logic       below;
    } t_chroma_quad;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       col;
        logic       row;
        logic       last;
    } t_rgb_pixel;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_mode = MODE_444;
    logic [7:0] i_luma_top_left = 8'd0;
    logic [7:0] i_luma_top_right = 8'd0;
    logic [7:0] i_luma_bottom_left = 8'd0;
    logic [7:0] i_luma_bottom_right = 8'd0;
    logic [7:0] i_chroma_blue = 8'd0;
    logic [7:0] i_chroma_red = 8'd0;
    logic       i_right_present = 1'b0;
    logic       i_below_present = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;
    logic       o_col_offset;
    logic       o_row_offset;
    logic       o_last_pixel;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_index = C_CFG_UNDERFLOW;
    logic [7:0] i_cfg_data = 8'd0;

    t_chroma_quad quad_backlog[$];
    t_rgb_pixel   expected_pixels[$];
    t_chroma_quad on_bus;
    t_chroma_quad next_quad;

    // Testbench copy of the replacement registers.
    logic [7:0] under_fill = C_UNDERFLOW_RESET;
    logic [7:0] over_fill  = C_OVERFLOW_RESET;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    ycbcr_to_rgb_subsampled_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_mode              (i_mode),
        .i_luma_top_left     (i_luma_top_left),
        .i_luma_top_right    (i_luma_top_right),
        .i_luma_bottom_left  (i_luma_bottom_left),
        .i_luma_bottom_right (i_luma_bottom_right),
        .i_chroma_blue       (i_chroma_blue),
        .i_chroma_red        (i_chroma_red),
        .i_right_present     (i_right_present),
        .i_below_present     (i_below_present),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_red               (o_red),
        .o_green             (o_green),
        .o_blue              (o_blue),
        .o_col_offset        (o_col_offset),
        .o_row_offset        (o_row_offset),
        .o_last_pixel        (o_last_pixel),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // Free-running clock, 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Floor the Q16 sum and substitute the register values when out of range.
    function automatic logic [7:0] saturate_channel(input int acc);
        int level;
        level = acc >>> 16;
        if (level < 0) begin
            return under_fill;
        end else if (level > 255) begin
            return over_fill;
        end
        return level[7:0];
    endfunction

    function automatic t_rgb_pixel convert_pixel(input logic [7:0] luma, input int cbd,
                                                 input int crd, input logic col,
                                                 input logic row);
        t_rgb_pixel px;
        int         y16;
        y16 = int'(luma) * 65536;
        px.red   = saturate_channel(y16 + CR_TO_RED * crd);
        px.green = saturate_channel(y16 - CB_TO_GREEN * cbd - CR_TO_GREEN * crd);
        px.blue  = saturate_channel(y16 + CB_TO_BLUE * cbd);
        px.col   = col;
        px.row   = row;
        px.last  = 1'b0;
        return px;
    endfunction

    // Work out the pixels of one accepted beat, in output order.
    task automatic predict_pixels(input t_chroma_quad q);
        t_rgb_pixel batch[$];
        int         cbd;
        int         crd;
        cbd = int'(q.cb) - CHROMA_ZERO;
        crd = int'(q.cr) - CHROMA_ZERO;
        batch.push_back(convert_pixel(q.y_tl, cbd, crd, 1'b0, 1'b0));
        if (q.mode != MODE_444 && q.right) begin
            batch.push_back(convert_pixel(q.y_tr, cbd, crd, 1'b1, 1'b0));
        end
        // The high mode bit selects quad sharing, so the reserved code behaves as 4:2:0.
        if (q.mode[1] && q.below) begin
            batch.push_back(convert_pixel(q.y_bl, cbd, crd, 1'b0, 1'b1));
            if (q.right) begin
                batch.push_back(convert_pixel(q.y_br, cbd, crd, 1'b1, 1'b1));
            end
        end
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k]) begin
            expected_pixels.push_back(batch[k]);
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: pixel %s mismatch, expected %0d, actual %0d",
                     $time, what, want, got);
            mismatches++;
        end
    endtask

    // Sender: a new beat is offered only once the previous one has gone.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                predict_pixels(on_bus);
            end
            if (quad_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_quad = quad_backlog.pop_front();
                on_bus              <= next_quad;
                i_valid             <= 1'b1;
                i_mode              <= next_quad.mode;
                i_luma_top_left     <= next_quad.y_tl;
                i_luma_top_right    <= next_quad.y_tr;
                i_luma_bottom_left  <= next_quad.y_bl;
                i_luma_bottom_right <= next_quad.y_br;
                i_chroma_blue       <= next_quad.cb;
                i_chroma_red        <= next_quad.cr;
                i_right_present     <= next_quad.right;
                i_below_present     <= next_quad.below;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: compare each accepted pixel with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel, expected none, actual r %0d g %0d b %0d",
                             $time, o_red, o_green, o_blue);
                    mismatches++;
                end else begin
                    check_field("red", expected_pixels[0].red, o_red);
                    check_field("green", expected_pixels[0].green, o_green);
                    check_field("blue", expected_pixels[0].blue, o_blue);
                    check_field("col_offset", 8'(expected_pixels[0].col),
                                8'(o_col_offset));
                    check_field("row_offset", 8'(expected_pixels[0].row),
                                8'(o_row_offset));
                    check_field("last_pixel", 8'(expected_pixels[0].last),
                                8'(o_last_pixel));
                    void'(expected_pixels.pop_front());
                end
            end
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Watchdog: give up when neither channel has moved a beat for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("** ycbcr_to_rgb_subsampled_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Bytes biased towards the extremes so that clamping is hit often.
    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) begin
            return 8'h00;
        end else if (roll == 1) begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_quad(input t_sampling mode, input logic [7:0] tl, input logic [7:0] tr,
                              input logic [7:0] bl, input logic [7:0] br,
                              input logic [7:0] cb, input logic [7:0] cr,
                              input logic right, input logic below);
        t_chroma_quad q;
        q.mode  = mode;
        q.y_tl  = tl;
        q.y_tr  = tr;
        q.y_bl  = bl;
        q.y_br  = br;
        q.cb    = cb;
        q.cr    = cr;
        q.right = right;
        q.below = below;
        quad_backlog.push_back(q);
    endtask

    task automatic queue_random(input int count);
        repeat (count) begin
            queue_quad(t_sampling'($urandom_range(0, 3)), pick_byte(), pick_byte(),
                       pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Wait until every beat has gone in and every pixel has come out.
    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (quad_backlog.size() != 0 || i_valid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Both replacement registers are written while idle, underflow first, then overflow.
    task automatic write_fill_values(input logic [7:0] under_val, input logic [7:0] over_val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= C_CFG_UNDERFLOW;
        i_cfg_data  <= under_val;
        @(posedge i_clk);
        i_cfg_index <= C_CFG_OVERFLOW;
        i_cfg_data  <= over_val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        under_fill = under_val;
        over_fill  = over_val;
        @(negedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed beats under the reset register values.
        send_idle_pct = 25;
        recv_idle_pct = 56;
        queue_quad(MODE_444, 8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128, 1'b0, 1'b0);
        queue_quad(MODE_444, 8'd255, 8'd17, 8'd99, 8'd200, 8'd128, 8'd128, 1'b1, 1'b1);
        queue_quad(MODE_444, 8'd128, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 1'b1, 1'b0);
        queue_quad(MODE_422, 8'd10, 8'd250, 8'd0, 8'd0, 8'd90, 8'd170, 1'b0, 1'b1);
        queue_quad(MODE_422, 8'd10, 8'd250, 8'd77, 8'd66, 8'd90, 8'd170, 1'b1, 1'b1);
        queue_quad(MODE_422, 8'd255, 8'd0, 8'd1, 8'd2, 8'd255, 8'd0, 1'b1, 1'b0);
        queue_quad(MODE_420, 8'd1, 8'd2, 8'd3, 8'd4, 8'd128, 8'd128, 1'b0, 1'b0);
        queue_quad(MODE_420, 8'd1, 8'd2, 8'd3, 8'd4, 8'd100, 8'd150, 1'b1, 1'b0);
        queue_quad(MODE_420, 8'd1, 8'd2, 8'd3, 8'd4, 8'd150, 8'd100, 1'b0, 1'b1);
        queue_quad(MODE_420, 8'd0, 8'd255, 8'd128, 8'd64, 8'd0, 8'd0, 1'b1, 1'b1);
        queue_quad(MODE_420, 8'd255, 8'd0, 8'd64, 8'd128, 8'd255, 8'd255, 1'b1, 1'b1);
        queue_quad(MODE_420, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b1, 1'b1);
        queue_quad(MODE_420, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 1'b1, 1'b1);
        queue_quad(MODE_RSVD, 8'd20, 8'd40, 8'd60, 8'd80, 8'd128, 8'd128, 1'b1, 1'b1);
        queue_quad(MODE_RSVD, 8'd200, 8'd220, 8'd240, 8'd5, 8'd30, 8'd230, 1'b0, 1'b1);
        queue_quad(MODE_RSVD, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
        queue_quad(MODE_444, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        queue_quad(MODE_444, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
        drain();

        // Replacement values at their extremes, then swapped, then random.
        write_fill_values(8'd0, 8'd255);
        queue_random(RANDOM_QUADS);
        drain();

        send_idle_pct = 56;
        recv_idle_pct = 25;
        write_fill_values(8'd255, 8'd0);
        queue_random(RANDOM_QUADS);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_fill_values(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        queue_random(RANDOM_QUADS);
        drain();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("** ycbcr_to_rgb_subsampled_unit: PASSED **");
        end else begin
            $display("** ycbcr_to_rgb_subsampled_unit: FAILED **");
        end
        $finish;
    end

endmodule
